// File: hdl/maze_backtracker_generator_unit_defines.svh
// Assertion macros shared by the maze generator RTL.
`ifndef MAZE_BACKTRACKER_GENERATOR_UNIT_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at each rising clock edge, not checked while reset is applied.
`define MBG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("maze generator assertion failed");
// Checked at each rising clock edge, also while reset is applied.
`define MBG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("maze generator assertion failed");
`else
`define MBG_ASSERT(lbl, prop)
`define MBG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hdl/maze_bt_pkg.sv
// Types, constants and helper functions of the maze generator.
package maze_bt_pkg;

  localparam int unsigned MaxSide    = 32;
  localparam int unsigned StackDepth = 1024;

  localparam int unsigned CoordW     = $clog2(MaxSide);
  localparam int unsigned SideW      = CoordW + 1;
  localparam int unsigned CellAddrW  = 2 * CoordW;
  localparam int unsigned StackAddrW = $clog2(StackDepth);
  localparam int unsigned DepthW     = StackAddrW + 1;
  localparam int unsigned CellW      = 5;
  localparam int unsigned RandW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 6;

  localparam int unsigned VisitedBit = 4;
  localparam logic [CellW-1:0] CellWallsAll = 5'h0F;
  localparam logic [CellW-1:0] CellVisited  = 5'h10;

  localparam logic [SideW-1:0] SideMin = SideW'(2);
  localparam logic [SideW-1:0] SideMax = SideW'(MaxSide);

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_STEP    = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_GRID_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_X   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_START_Y   = 2'd2;

  typedef enum logic [1:0] {
    ACT_CARVED      = 2'd0,
    ACT_BACKTRACKED = 2'd1,
    ACT_DONE        = 2'd2,
    ACT_RESTARTED   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic             command;
    logic [RandW-1:0] random_value;
  } maze_bt_in_t;

  typedef struct packed {
    action_e           action;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    dir_e              carved_dir;
    logic [DepthW-1:0] stack_depth;
  } maze_bt_out_t;

  // Remainder by three: base-4 digits sum to the same residue, folded twice.
  function automatic logic [1:0] mod3(input logic [RandW-1:0] v);
    logic [3:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s  = {2'b00, v[7:6]} + {2'b00, v[5:4]} + {2'b00, v[3:2]} + {2'b00, v[1:0]};
    s2 = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    s3 = {2'b00, s2[2]} + {1'b0, s2[1:0]};
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

  // Random value modulo the number of open neighbors (one to four).
  function automatic logic [1:0] pick_index(input logic [RandW-1:0] v,
                                            input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = mod3(v);
      3'd4:    r = v[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/maze_backtracker_generator_unit.sv
// Top level of the maze generator: cell memory, path stack and step sequencer.
//
// The block carves a maze by randomized depth-first search. Items arrive on the
// input channel (in_valid_i / in_ready_o / in_data_i) and every item produces
// exactly one result on the output channel (out_valid_o / out_ready_i /
// out_data_o). A restart item rebuilds the grid, a step item carves one cell,
// backs up one cell, or reports done.
//
// A carve runs through ST_READ, ST_WAIT, ST_PICK, ST_WR1, ST_WR2 and ST_EMIT:
// the cell memory has a single read port, so the four neighbors and the
// current cell are read one per cycle; the last data arrives in ST_WAIT and
// ST_PICK decides, and its single write port then updates the two cells of a
// carve in ST_WR1 and ST_WR2. A backtrack to a new stack top waits in ST_POPD
// for that entry; popping the last entry or a done report goes from ST_PICK
// straight to ST_EMIT. A restart sweeps all 1024 cell entries, one per cycle,
// before its result is emitted. Each result turns valid as in_ready_o rises.
//
// After reset the same sweep runs with in_ready_o low; configuration
// writes are taken at any time. The result sits in an output register, so the
// next input transfer is taken while it waits. If the receiver keeps stalling,
// the following result waits inside the block and no further input is taken.
module maze_backtracker_generator_unit
  import maze_bt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  maze_bt_in_t         in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output maze_bt_out_t        out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

`include "maze_backtracker_generator_unit_defines.svh"

  // Sequencer states.
  localparam logic [3:0] ST_CLR   = 4'd0;  // Sweep of the cell memory.
  localparam logic [3:0] ST_IDLE  = 4'd1;  // Waiting for an input transfer.
  localparam logic [3:0] ST_READ  = 4'd2;  // Reading neighbors and current cell.
  localparam logic [3:0] ST_WAIT  = 4'd3;  // Last read data arrives.
  localparam logic [3:0] ST_PICK  = 4'd4;  // Choose carve, backtrack or done.
  localparam logic [3:0] ST_WR1   = 4'd5;  // Open the wall of the current cell.
  localparam logic [3:0] ST_WR2   = 4'd6;  // Open and mark the new cell, push.
  localparam logic [3:0] ST_POPD  = 4'd7;  // New stack top arrives.
  localparam logic [3:0] ST_EMIT  = 4'd8;  // Hand the result to the output reg.

  localparam logic [2:0] ReadCur = 3'd4;  // Read slot of the current cell.

  // Configuration registers.
  logic [CfgDataW-1:0] grid_size_q;
  logic [CoordW-1:0]   start_x_q;
  logic [CoordW-1:0]   start_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= CfgDataW'(10);
      start_x_q   <= CoordW'(9);
      start_y_q   <= CoordW'(9);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_SIZE: grid_size_q <= cfg_data_i;
        REG_START_X:   start_x_q   <= cfg_data_i[CoordW-1:0];
        REG_START_Y:   start_y_q   <= cfg_data_i[CoordW-1:0];
        default:       ;
      endcase
    end
  end

  // Side length in use, clamped to the supported range.
  logic [SideW-1:0] side;
  logic [SideW-1:0] grid_size_w;
  assign grid_size_w = SideW'(grid_size_q);
  always_comb begin
    if (grid_size_w < SideMin) begin
      side = SideMin;
    end else if (grid_size_w > SideMax) begin
      side = SideMax;
    end else begin
      side = grid_size_w;
    end
  end

  // Start cell, each coordinate saturated to the last row or column.
  logic [CoordW-1:0] start_x_sat;
  logic [CoordW-1:0] start_y_sat;
  logic [SideW-1:0]  side_m1;
  assign side_m1     = side - SideW'(1);
  assign start_x_sat = ({1'b0, start_x_q} >= side) ? side_m1[CoordW-1:0] : start_x_q;
  assign start_y_sat = ({1'b0, start_y_q} >= side) ? side_m1[CoordW-1:0] : start_y_q;

  // Sequencer and datapath registers.
  logic [3:0]           state_q, state_d;
  logic [2:0]           rd_cnt_q, rd_cnt_d;
  logic                 rd_vld_q;
  logic [2:0]           rd_dir_q;
  logic [RandW-1:0]     rnd_q, rnd_d;
  logic [1:0]           pick_q, pick_d;
  logic [CoordW-1:0]    cur_x_q, cur_x_d;
  logic [CoordW-1:0]    cur_y_q, cur_y_d;
  logic [DepthW-1:0]    count_q, count_d;
  logic [CellAddrW-1:0] clr_addr_q, clr_addr_d;
  logic                 clr_restart_q, clr_restart_d;
  logic [CellAddrW-1:0] start_cell_q, start_cell_d;
  maze_bt_out_t         res_q, res_d;
  logic                 out_valid_q;
  maze_bt_out_t         out_data_q;
  logic [CellW-1:0]     nb_q [4];
  logic [CellW-1:0]     cur_cell_q;

  // Cell memory: walls up, down, left, right in bits 0 to 3, visited in bit 4.
  logic [CellW-1:0]     cell_mem [MaxSide*MaxSide];
  logic                 cell_we;
  logic [CellAddrW-1:0] cell_waddr;
  logic [CellW-1:0]     cell_wdata;
  logic [CellAddrW-1:0] cell_raddr;
  logic [CellW-1:0]     cell_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[cell_raddr];
  end

  // Path stack: packed cell addresses, row in the upper half.
  logic [CellAddrW-1:0]  stack_mem [StackDepth];
  logic                  stack_we;
  logic [StackAddrW-1:0] stack_waddr;
  logic [CellAddrW-1:0]  stack_wdata;
  logic [StackAddrW-1:0] stack_raddr;
  logic [CellAddrW-1:0]  stack_rdata_q;
  logic [DepthW-1:0]     count_m2;

  // The entry below the top; read while deciding, so it is ready after a pop.
  assign count_m2    = count_q - DepthW'(2);
  assign stack_raddr = count_m2[StackAddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  // Neighbor coordinates and whether each lies inside the grid.
  logic [SideW-1:0]     nbx6 [4];
  logic [SideW-1:0]     nby6 [4];
  logic [CellAddrW-1:0] nb_addr [4];
  logic [3:0]           in_grid;
  logic [3:0]           unvisited;
  logic [2:0]           open_cnt;
  logic [CellAddrW-1:0] cur_addr;

  assign cur_addr = {cur_y_q, cur_x_q};

  always_comb begin
    nbx6[DIR_UP]    = {1'b0, cur_x_q};
    nby6[DIR_UP]    = {1'b0, cur_y_q} - SideW'(1);
    nbx6[DIR_DOWN]  = {1'b0, cur_x_q};
    nby6[DIR_DOWN]  = {1'b0, cur_y_q} + SideW'(1);
    nbx6[DIR_LEFT]  = {1'b0, cur_x_q} - SideW'(1);
    nby6[DIR_LEFT]  = {1'b0, cur_y_q};
    nbx6[DIR_RIGHT] = {1'b0, cur_x_q} + SideW'(1);
    nby6[DIR_RIGHT] = {1'b0, cur_y_q};
    for (int d = 0; d < 4; d++) begin
      nb_addr[d] = {nby6[d][CoordW-1:0], nbx6[d][CoordW-1:0]};
      in_grid[d] = (nbx6[d] < side) && (nby6[d] < side);
    end
    // A step below zero wraps to a large value; those two also get a test against zero.
    in_grid[DIR_UP]   = in_grid[DIR_UP] && (cur_y_q != '0);
    in_grid[DIR_LEFT] = in_grid[DIR_LEFT] && (cur_x_q != '0);
    for (int d = 0; d < 4; d++) begin
      unvisited[d] = in_grid[d] && !nb_q[d][VisitedBit];
    end
    open_cnt = 3'($countones(unvisited));
  end

  // Capture of read data: four neighbors, then the current cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_dir_q <= '0;
    end else begin
      rd_vld_q <= (state_q == ST_READ);
      rd_dir_q <= rd_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (rd_dir_q == ReadCur) begin
        cur_cell_q <= cell_rdata_q;
      end else begin
        nb_q[rd_dir_q[1:0]] <= cell_rdata_q;
      end
    end
  end

  // Output register is free when empty or when its result leaves this cycle.
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer.
  always_comb begin
    logic [1:0]           sel;
    logic [2:0]           seen;
    logic [CellAddrW-1:0] new_cell;

    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    rnd_d         = rnd_q;
    pick_d        = pick_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    count_d       = count_q;
    clr_addr_d    = clr_addr_q;
    clr_restart_d = clr_restart_q;
    start_cell_d  = start_cell_q;
    res_d         = res_q;

    cell_we     = 1'b0;
    cell_waddr  = clr_addr_q;
    cell_wdata  = CellWallsAll;
    cell_raddr  = (rd_cnt_q == ReadCur) ? cur_addr : nb_addr[rd_cnt_q[1:0]];
    stack_we    = 1'b0;
    stack_waddr = count_q[StackAddrW-1:0];
    stack_wdata = nb_addr[pick_q];

    sel      = pick_index(rnd_q, open_cnt);
    seen     = '0;
    new_cell = nb_addr[pick_q];

    case (state_q)
      ST_CLR: begin
        // Every cell gets four walls; on a restart the start cell is visited.
        cell_we    = 1'b1;
        cell_waddr = clr_addr_q;
        if (clr_restart_q && (clr_addr_q == start_cell_q)) begin
          cell_wdata = CellWallsAll | CellVisited;
        end
        clr_addr_d = clr_addr_q + CellAddrW'(1);
        if (clr_addr_q == '1) begin
          if (clr_restart_q) begin
            res_d.action      = ACT_RESTARTED;
            res_d.pos_x       = cur_x_q;
            res_d.pos_y       = cur_y_q;
            res_d.carved_dir  = DIR_UP;
            res_d.stack_depth = count_q;
            state_d           = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          rnd_d = in_data_i.random_value;
          if (in_data_i.command == CMD_RESTART) begin
            cur_x_d       = start_x_sat;
            cur_y_d       = start_y_sat;
            start_cell_d  = {start_y_sat, start_x_sat};
            count_d       = DepthW'(1);
            stack_we      = 1'b1;
            stack_waddr   = '0;
            stack_wdata   = {start_y_sat, start_x_sat};
            clr_addr_d    = '0;
            clr_restart_d = 1'b1;
            state_d       = ST_CLR;
          end else begin
            rd_cnt_d = '0;
            state_d  = ST_READ;
          end
        end
      end

      ST_READ: begin
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == ReadCur) begin
          state_d = ST_WAIT;
        end
      end

      ST_WAIT: begin
        state_d = ST_PICK;
      end

      ST_PICK: begin
        if (open_cnt != '0) begin
          // Take the sel-th open neighbor in the order up, down, left, right.
          for (int d = 0; d < 4; d++) begin
            if (unvisited[d]) begin
              if (seen == {1'b0, sel}) begin
                pick_d = 2'(d);
              end
              seen = seen + 3'd1;
            end
          end
          state_d = ST_WR1;
        end else if (count_q != '0) begin
          count_d = count_q - DepthW'(1);
          if (count_q > DepthW'(1)) begin
            state_d = ST_POPD;
          end else begin
            // The last entry leaves the stack and the position stays.
            res_d.action      = ACT_BACKTRACKED;
            res_d.pos_x       = cur_x_q;
            res_d.pos_y       = cur_y_q;
            res_d.carved_dir  = DIR_UP;
            res_d.stack_depth = count_d;
            state_d           = ST_EMIT;
          end
        end else begin
          res_d.action      = ACT_DONE;
          res_d.pos_x       = cur_x_q;
          res_d.pos_y       = cur_y_q;
          res_d.carved_dir  = DIR_UP;
          res_d.stack_depth = count_q;
          state_d           = ST_EMIT;
        end
      end

      ST_WR1: begin
        cell_we    = 1'b1;
        cell_waddr = cur_addr;
        cell_wdata = cur_cell_q & ~(CellW'(1) << pick_q);
        state_d    = ST_WR2;
      end

      ST_WR2: begin
        // The opposite wall of the new cell: up and down, left and right swap.
        cell_we    = 1'b1;
        cell_waddr = new_cell;
        cell_wdata = (nb_q[pick_q] & ~(CellW'(1) << (pick_q ^ 2'b01))) | CellVisited;
        cur_x_d    = new_cell[CoordW-1:0];
        cur_y_d    = new_cell[CellAddrW-1:CoordW];
        if (count_q < DepthW'(StackDepth)) begin
          stack_we    = 1'b1;
          stack_waddr = count_q[StackAddrW-1:0];
          stack_wdata = new_cell;
          count_d     = count_q + DepthW'(1);
        end
        res_d.action      = ACT_CARVED;
        res_d.pos_x       = cur_x_d;
        res_d.pos_y       = cur_y_d;
        res_d.carved_dir  = dir_e'(pick_q);
        res_d.stack_depth = count_d;
        state_d           = ST_EMIT;
      end

      ST_POPD: begin
        cur_x_d           = stack_rdata_q[CoordW-1:0];
        cur_y_d           = stack_rdata_q[CellAddrW-1:CoordW];
        res_d.action      = ACT_BACKTRACKED;
        res_d.pos_x       = cur_x_d;
        res_d.pos_y       = cur_y_d;
        res_d.carved_dir  = DIR_UP;
        res_d.stack_depth = count_q;
        state_d           = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      rd_cnt_q      <= '0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      count_q       <= '0;
      clr_addr_q    <= '0;
      clr_restart_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_cnt_q      <= rd_cnt_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      count_q       <= count_d;
      clr_addr_q    <= clr_addr_d;
      clr_restart_q <= clr_restart_d;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q        <= rnd_d;
    pick_q       <= pick_d;
    start_cell_q <= start_cell_d;
    res_q        <= res_d;
    if ((state_q == ST_EMIT) && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A restart transfer always starts a full sweep from the first entry.
  `MBG_ASSERT(a_restart_sweeps,
    (in_valid_i && in_ready_o && (in_data_i.command == CMD_RESTART))
    |=> ((state_q == ST_CLR) && (clr_addr_q == '0) && clr_restart_q))

  // A waiting result is never overwritten: the sequencer holds in its handoff state.
  `MBG_ASSERT(a_emit_holds,
    ((state_q == ST_EMIT) && out_valid_o && !out_ready_i)
    |=> ((state_q == ST_EMIT) && out_valid_o))

  // The path stack never counts beyond its storage.
  `MBG_ASSERT_ALWAYS(a_depth_bound, !rst_ni || (count_q <= DepthW'(StackDepth)))

  // Only a carve reports a direction other than up.
  `MBG_ASSERT(a_dir_only_on_carve,
    (out_valid_o && (out_data_o.action != ACT_CARVED)) |-> (out_data_o.carved_dir == DIR_UP))

endmodule
